// ===== src/text_console_cursor_engine_defines.svh =====
// Assertion macros shared by the text console RTL.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_DEFINES_SVH

// Invariant that must hold at every clock edge out of reset.
`define TCCE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TCCE_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tcce_pkg.sv =====
// Types, constants and helpers for the text console cursor engine.
package tcce_pkg;

    localparam int WIDTH_DEF  = 80;
    localparam int HEIGHT_DEF = 25;

    localparam int CELL_W   = 16;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int MODE_W   = 2;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int POS_W    = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hf;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0d;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // Register index, taken from paddr[2]
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_BACK  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_FILL,
        S_OUT
    } t_state;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input logic [CHAR_W-1:0]  ch
    );
        return {bg, fg, ch};
    endfunction

endpackage

// ===== src/tcce_cell_ram.sv =====
// Single-port cell memory with registered read data.
module tcce_cell_ram #(
    parameter int DEPTH  = tcce_pkg::WIDTH_DEF * tcce_pkg::HEIGHT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_addr,
    input  logic [tcce_pkg::CELL_W-1:0] i_wdata,
    output logic [tcce_pkg::CELL_W-1:0] o_rdata
);

    logic [tcce_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcce_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/text_console_cursor_engine.sv =====
// Top level of the character-cell text console with cursor.
//
//  channel   dir  handshake                   payload
//  --------  ---  --------------------------  ------------------------------------------
//  in        in   i_in_valid / o_in_stall     i_mode, i_char_code, i_read_row, i_read_col
//  out       out  o_out_valid / i_out_stall   o_cursor_pos, o_cell_char, o_cell_attr
//  config    in   psel, penable, pwrite       paddr, pwdata -> prdata (pready tied high)
//
//  Put, backspace, newline and read step through accept, row translate, memory access
//  and result load. A scroll adds a sweep that blanks the new bottom row, one cell
//  write per cycle; a clear sweeps all WIDTH*HEIGHT cells the same way. Reset clears
//  the sequencer, cursor, scroll offset and colors; the cell store is undefined until
//  the first clear. A stalled result holds in the output register while the next item
//  is already taken in.

module text_console_cursor_engine #(
    parameter int WIDTH  = tcce_pkg::WIDTH_DEF,
    parameter int HEIGHT = tcce_pkg::HEIGHT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tcce_pkg::MODE_W-1:0]   i_mode,
    input  logic [tcce_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcce_pkg::RROW_W-1:0]   i_read_row,
    input  logic [tcce_pkg::RCOL_W-1:0]   i_read_col,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tcce_pkg::POS_W-1:0]    o_cursor_pos,
    output logic [tcce_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcce_pkg::CHAR_W-1:0]   o_cell_attr,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcce_pkg::PADDR_W-1:0]  paddr,
    input  logic [tcce_pkg::PDATA_W-1:0]  pwdata,
    output logic [tcce_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    `include "text_console_cursor_engine_defines.svh"

    localparam int CELLS  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(WIDTH);
    localparam int ROW_W  = $clog2(HEIGHT);
    localparam int CNT_W  = $clog2(CELLS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [tcce_pkg::COLOR_W-1:0] r_fg;
    logic [tcce_pkg::COLOR_W-1:0] r_bg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcce_pkg::FG_RESET;
            r_bg <= tcce_pkg::BG_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                tcce_pkg::REG_FG: r_fg <= pwdata[tcce_pkg::COLOR_W-1:0];
                tcce_pkg::REG_BG: r_bg <= pwdata[tcce_pkg::COLOR_W-1:0];
                default:          r_fg <= r_fg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tcce_pkg::REG_FG: prdata = tcce_pkg::PDATA_W'(r_fg);
            tcce_pkg::REG_BG: prdata = tcce_pkg::PDATA_W'(r_bg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    tcce_pkg::t_state r_state, n_state;

    // latched item
    tcce_pkg::t_mode             r_mode, n_mode;
    logic [tcce_pkg::CHAR_W-1:0] r_char, n_char;
    logic [tcce_pkg::RROW_W-1:0] r_rd_row, n_rd_row;
    logic [tcce_pkg::RCOL_W-1:0] r_rd_col, n_rd_col;

    // cursor in logical coordinates, plus physical row of the top line
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic [ROW_W-1:0] r_top, n_top;

    // translated access
    logic [ROW_W-1:0] r_prow, n_prow;
    logic [COL_W-1:0] r_acol, n_acol;
    logic             r_in_range, n_in_range;

    // blanking sweep
    logic [ADDR_W-1:0] r_fill_addr, n_fill_addr;
    logic [CNT_W-1:0]  r_fill_left, n_fill_left;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [tcce_pkg::POS_W-1:0]   r_cursor_pos, n_cursor_pos;
    logic [tcce_pkg::CHAR_W-1:0]  r_cell_char, n_cell_char;
    logic [tcce_pkg::CHAR_W-1:0]  r_cell_attr, n_cell_attr;

    // memory port
    logic                          mem_we;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_addr;
    logic [tcce_pkg::CELL_W-1:0]   mem_wdata;
    logic [tcce_pkg::CELL_W-1:0]   mem_rdata;

    // helpers
    logic                         in_fire;
    logic                         row_last;
    logic                         col_last;
    logic [ROW_W-1:0]             lrow;
    logic [ROW_W:0]               row_sum;
    logic [ADDR_W-1:0]            exec_addr;
    logic [tcce_pkg::CELL_W-1:0]  blank_cell;
    logic                         is_newline;

    assign in_fire    = i_in_valid && (r_state == tcce_pkg::S_IDLE);
    assign o_in_stall = (r_state != tcce_pkg::S_IDLE);

    assign row_last   = (r_cur_row == ROW_W'(HEIGHT - 1));
    assign col_last   = (r_cur_col == COL_W'(WIDTH - 1));
    assign is_newline = (r_char == tcce_pkg::CH_NEWLINE) || (r_char == tcce_pkg::CH_RETURN);
    assign blank_cell = tcce_pkg::make_cell(r_fg, r_bg, tcce_pkg::CH_SPACE);

    // logical row to physical row: the offset sum stays below twice HEIGHT for in-range rows
    assign lrow    = (r_mode == tcce_pkg::MODE_READ) ? ROW_W'(r_rd_row) : r_cur_row;
    assign row_sum = (ROW_W + 1)'(r_top) + (ROW_W + 1)'(lrow);

    assign exec_addr = ADDR_W'(r_prow * WIDTH) + ADDR_W'(r_acol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcce_pkg::S_IDLE;
            r_cur_col   <= '0;
            r_cur_row   <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_col   <= n_cur_col;
            r_cur_row   <= n_cur_row;
            r_top       <= n_top;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_char       <= n_char;
        r_rd_row     <= n_rd_row;
        r_rd_col     <= n_rd_col;
        r_prow       <= n_prow;
        r_acol       <= n_acol;
        r_in_range   <= n_in_range;
        r_fill_addr  <= n_fill_addr;
        r_fill_left  <= n_fill_left;
        r_cursor_pos <= n_cursor_pos;
        r_cell_char  <= n_cell_char;
        r_cell_attr  <= n_cell_attr;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_char       = r_char;
        n_rd_row     = r_rd_row;
        n_rd_col     = r_rd_col;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_top        = r_top;
        n_prow       = r_prow;
        n_acol       = r_acol;
        n_in_range   = r_in_range;
        n_fill_addr  = r_fill_addr;
        n_fill_left  = r_fill_left;
        n_out_valid  = r_out_valid && i_out_stall;
        n_cursor_pos = r_cursor_pos;
        n_cell_char  = r_cell_char;
        n_cell_attr  = r_cell_attr;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = exec_addr;
        mem_wdata    = blank_cell;

        unique case (r_state)
            tcce_pkg::S_IDLE: begin
                // take the item in even while the last result waits
                if (in_fire) begin
                    n_mode   = tcce_pkg::t_mode'(i_mode);
                    n_char   = i_char_code;
                    n_rd_row = i_read_row;
                    n_rd_col = i_read_col;
                    n_state  = tcce_pkg::S_ADDR;
                end
            end

            tcce_pkg::S_ADDR: begin
                // translate the target row through the scroll offset
                n_prow     = (row_sum >= (ROW_W + 1)'(HEIGHT))
                           ? ROW_W'(row_sum - (ROW_W + 1)'(HEIGHT))
                           : ROW_W'(row_sum);
                n_acol     = (r_mode == tcce_pkg::MODE_READ) ? COL_W'(r_rd_col) : r_cur_col;
                n_in_range = (32'(r_rd_row) < 32'(HEIGHT)) && (32'(r_rd_col) < 32'(WIDTH));
                n_state    = tcce_pkg::S_EXEC;
            end

            tcce_pkg::S_EXEC: begin
                n_state = tcce_pkg::S_OUT;
                case (r_mode)
                    tcce_pkg::MODE_PUT: begin
                        if (!is_newline) begin
                            // store the character at the cursor
                            mem_we    = 1'b1;
                            mem_wdata = tcce_pkg::make_cell(r_fg, r_bg, r_char);
                        end
                        if (!is_newline && !col_last) begin
                            n_cur_col = r_cur_col + COL_W'(1);
                        end else begin
                            // newline or wrap: next row, or scroll at the bottom
                            n_cur_col = '0;
                            if (!row_last) begin
                                n_cur_row = r_cur_row + ROW_W'(1);
                            end else begin
                                // old top line becomes the new, blank bottom line
                                n_top       = (r_top == ROW_W'(HEIGHT - 1))
                                            ? '0 : r_top + ROW_W'(1);
                                n_fill_addr = ADDR_W'(r_top * WIDTH);
                                n_fill_left = CNT_W'(WIDTH);
                                n_state     = tcce_pkg::S_FILL;
                            end
                        end
                    end
                    tcce_pkg::MODE_BACK: begin
                        if (r_cur_col != '0) begin
                            n_cur_col = r_cur_col - COL_W'(1);
                        end else if (r_cur_row != '0) begin
                            n_cur_col = COL_W'(WIDTH - 1);
                            n_cur_row = r_cur_row - ROW_W'(1);
                        end
                    end
                    tcce_pkg::MODE_CLEAR: begin
                        n_cur_col   = '0;
                        n_cur_row   = '0;
                        n_top       = '0;
                        n_fill_addr = '0;
                        n_fill_left = CNT_W'(CELLS);
                        n_state     = tcce_pkg::S_FILL;
                    end
                    default: begin
                        // read: data lands in the memory output register next cycle
                        mem_re = r_in_range;
                    end
                endcase
            end

            tcce_pkg::S_FILL: begin
                // blank one cell per cycle
                mem_we      = 1'b1;
                mem_addr    = r_fill_addr;
                n_fill_addr = r_fill_addr + ADDR_W'(1);
                n_fill_left = r_fill_left - CNT_W'(1);
                if (r_fill_left == CNT_W'(1)) begin
                    n_state = tcce_pkg::S_OUT;
                end
            end

            tcce_pkg::S_OUT: begin
                // load the result once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_cursor_pos = tcce_pkg::POS_W'(r_cur_row * WIDTH + 32'(r_cur_col));
                    if ((r_mode == tcce_pkg::MODE_READ) && r_in_range) begin
                        n_cell_char = mem_rdata[tcce_pkg::CHAR_W-1:0];
                        n_cell_attr = mem_rdata[tcce_pkg::CELL_W-1:tcce_pkg::CHAR_W];
                    end else begin
                        n_cell_char = '0;
                        n_cell_attr = '0;
                    end
                    n_state = tcce_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tcce_pkg::S_IDLE;
            end
        endcase
    end

    tcce_cell_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_cursor_pos;
    assign o_cell_char  = r_cell_char;
    assign o_cell_attr  = r_cell_attr;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TCCE_ASSERT_ALWAYS(a_cursor_on_screen,
        (32'(r_cur_row) < 32'(HEIGHT)) && (32'(r_cur_col) < 32'(WIDTH)),
        "cursor left the screen")

    `TCCE_ASSERT_ALWAYS(a_top_in_range, 32'(r_top) < 32'(HEIGHT),
        "scroll offset out of range")

    `TCCE_ASSERT_IMPLIES(a_fill_bounded, r_state == tcce_pkg::S_FILL,
        (r_fill_left != '0) && (32'(r_fill_addr) + 32'(r_fill_left) <= 32'(CELLS)),
        "blanking sweep runs past the cell store")

    `TCCE_ASSERT_IMPLIES(a_result_from_out, $rose(r_out_valid),
        $past(r_state) == tcce_pkg::S_OUT,
        "result appeared outside the result load step")

endmodule
